// File: hdl/mtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_pkg: shared types and constants of the mutex table lock unit
// Field widths, operation and status codes, the decoded request that
// travels from the front end to the back end through the request queue.
// ----------------------------------------------------------------------------
package mtl_pkg;

  // parameter defaults
  localparam int MutexCountDef = 16;
  localparam int PidWidthDef   = 16;

  // fixed field widths
  localparam int OpW     = 3;
  localparam int IdW     = 4;
  localparam int RawPidW = 16;
  localparam int StatusW = 2;
  localparam int ValueW  = 16;

  // depth of the queue between front and back end
  localparam int QueueDepth = 2;

  // operation codes on the request channel
  localparam logic [OpW-1:0] OP_CREATE  = 3'd0;
  localparam logic [OpW-1:0] OP_LOCK    = 3'd1;
  localparam logic [OpW-1:0] OP_UNLOCK  = 3'd2;
  localparam logic [OpW-1:0] OP_TRYLOCK = 3'd3;
  localparam logic [OpW-1:0] OP_OWNER   = 3'd4;

  // status codes on the response channel
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_ERROR = 2'd1;
  localparam logic [StatusW-1:0] ST_RETRY = 2'd2;

  // request class decided by the front end
  typedef enum logic [2:0] {
    KIND_CREATE,
    KIND_LOCK,
    KIND_UNLOCK,
    KIND_TRYLOCK,
    KIND_OWNER,
    KIND_ERROR
  } kind_e;

  // decoded request held in the queue
  typedef struct packed {
    kind_e               kind;
    logic [IdW-1:0]      idx;
    logic [RawPidW-1:0]  pid;
  } req_t;

endpackage : mtl_pkg
`default_nettype wire

// File: hdl/mtl_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_req_if: request channel of the mutex table lock unit
// Valid/ready channel carrying operation, mutex id and requester pid.
// ----------------------------------------------------------------------------
interface mtl_req_if
  import mtl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [IdW-1:0]     mutex_id;
  logic [RawPidW-1:0] requester_pid;

  modport source (output valid, output op, output mutex_id, output requester_pid,
                  input ready);
  modport sink   (input valid, input op, input mutex_id, input requester_pid,
                  output ready);
endinterface : mtl_req_if
`default_nettype wire

// File: hdl/mtl_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_rsp_if: response channel of the mutex table lock unit
// Valid/ready channel carrying status, value and the wake flag.
// ----------------------------------------------------------------------------
interface mtl_rsp_if
  import mtl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  value;
  logic               wake_waiters;

  modport source (output valid, output status, output value, output wake_waiters,
                  input ready);
  modport sink   (input valid, input status, input value, input wake_waiters,
                  output ready);
endinterface : mtl_rsp_if
`default_nettype wire

// File: hdl/mtl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_front: request decoder
// Classifies each request beat: maps the op code to a request kind and
// turns unknown ops and out-of-range ids into an error request.
// ----------------------------------------------------------------------------
module mtl_front
  import mtl_pkg::*;
#(
  parameter int MUTEX_COUNT = MutexCountDef
) (
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [OpW-1:0]     op_i,
  input  wire logic [IdW-1:0]     mutex_id_i,
  input  wire logic [RawPidW-1:0] requester_pid_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output req_t                    push_req_o
);

  logic id_ok;

  // id must address an existing table slot (create ignores it)
  assign id_ok = 32'(mutex_id_i) < 32'(MUTEX_COUNT);

  // classify
  always_comb begin
    push_req_o.idx  = mutex_id_i;
    push_req_o.pid  = requester_pid_i;
    push_req_o.kind = KIND_ERROR;
    case (op_i)
      OP_CREATE:  push_req_o.kind = KIND_CREATE;
      OP_LOCK:    push_req_o.kind = id_ok ? KIND_LOCK    : KIND_ERROR;
      OP_UNLOCK:  push_req_o.kind = id_ok ? KIND_UNLOCK  : KIND_ERROR;
      OP_TRYLOCK: push_req_o.kind = id_ok ? KIND_TRYLOCK : KIND_ERROR;
      OP_OWNER:   push_req_o.kind = id_ok ? KIND_OWNER   : KIND_ERROR;
      default:    push_req_o.kind = KIND_ERROR;
    endcase
  end

  assign push_valid_o = valid_i;
  assign ready_o      = push_ready_i;

endmodule : mtl_front
`default_nettype wire

// File: hdl/mtl_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_fifo: request queue
// Small register queue between decoder and executor; takes a beat while
// not full and presents its oldest entry to the back end.
// ----------------------------------------------------------------------------
module mtl_fifo
  import mtl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire req_t push_req_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output req_t      pop_req_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  req_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_req_o    = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_req_i;
    end
  end

endmodule : mtl_fifo
`default_nettype wire

// File: hdl/mtl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_back: mutex table executor
// Holds table, fill count and response register; with that register free or
// draining, it runs one request per cycle as a read-modify-write of one entry.
// ----------------------------------------------------------------------------
module mtl_back
  import mtl_pkg::*;
#(
  parameter int MUTEX_COUNT = MutexCountDef,
  parameter int PID_WIDTH   = PidWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire req_t               req_i,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_ready_i,
  output logic [StatusW-1:0]      rsp_status_o,
  output logic [ValueW-1:0]       rsp_value_o,
  output logic                    rsp_wake_o
);

  // ids are IdW bits wide, so at most 2**IdW entries can ever be addressed
  localparam int TableDepth = (MUTEX_COUNT < (1 << IdW)) ? MUTEX_COUNT : (1 << IdW);
  localparam int TidxW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(MUTEX_COUNT + 1);

  // entries are created lowest first and never destroyed: used == below count
  logic [CntW-1:0]       cnt_q;
  logic [TableDepth-1:0] locked_q;
  logic [PID_WIDTH-1:0]  owner_q [TableDepth];

  logic                  rsp_valid_q;
  logic [StatusW-1:0]    status_q, status_d;
  logic [ValueW-1:0]     value_q, value_d;
  logic                  wake_q, wake_d;

  logic                  issue;
  logic [TidxW-1:0]      tidx;
  logic [31:0]           pid_wide, owner_wide;
  logic [PID_WIDTH-1:0]  pid_tag;
  logic                  used, locked, owner_match, full;
  logic                  set_lock, clr_lock, bump;

  // accept from the queue when the response register is free or draining
  assign issue       = req_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = issue;

  // entry read
  assign tidx        = req_i.idx[TidxW-1:0];
  assign pid_wide    = 32'(req_i.pid);
  assign pid_tag     = pid_wide[PID_WIDTH-1:0];
  assign owner_wide  = 32'(owner_q[tidx]);
  assign used        = 32'(req_i.idx) < 32'(cnt_q);
  assign locked      = locked_q[tidx];
  assign owner_match = owner_q[tidx] == pid_tag;
  assign full        = cnt_q == CntW'(MUTEX_COUNT);

  // execute
  always_comb begin
    status_d = ST_ERROR;
    value_d  = '0;
    wake_d   = 1'b0;
    set_lock = 1'b0;
    clr_lock = 1'b0;
    bump     = 1'b0;
    case (req_i.kind)
      KIND_CREATE: begin
        if (!full) begin
          status_d = ST_OK;
          value_d  = ValueW'(cnt_q);
          bump     = 1'b1;
        end
      end
      KIND_LOCK: begin
        if (used) begin
          if (!locked) begin
            status_d = ST_OK;
            set_lock = 1'b1;
          end else if (!owner_match) begin
            status_d = ST_RETRY;
          end
        end
      end
      KIND_UNLOCK: begin
        if (used && locked && owner_match) begin
          status_d = ST_OK;
          wake_d   = 1'b1;
          clr_lock = 1'b1;
        end
      end
      KIND_TRYLOCK: begin
        if (used && !locked) begin
          status_d = ST_OK;
          set_lock = 1'b1;
        end
      end
      KIND_OWNER: begin
        if (used) begin
          status_d = ST_OK;
          value_d  = locked ? owner_wide[ValueW-1:0] : '0;
        end
      end
      default: begin
        status_d = ST_ERROR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      locked_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (issue && bump) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (issue && set_lock) begin
        locked_q[tidx] <= 1'b1;
      end else if (issue && clr_lock) begin
        locked_q[tidx] <= 1'b0;
      end
      if (issue) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // owner tags and response payload; owner is only read while locked
  always_ff @(posedge clk_i) begin
    if (issue && set_lock) begin
      owner_q[tidx] <= pid_tag;
    end
    if (issue) begin
      status_q <= status_d;
      value_q  <= value_d;
      wake_q   <= wake_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = status_q;
  assign rsp_value_o  = value_q;
  assign rsp_wake_o   = wake_q;

  // a granted lock leaves the entry held
  a_lock_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && set_lock) |=> locked_q[$past(tidx)])
    else $error("granted entry not marked locked");

  // a wake response leaves the entry free
  a_wake_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && wake_d) |=> !locked_q[$past(tidx)])
    else $error("entry still locked after wake");

  // the fill count moves only on a successful create
  a_cnt_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(issue && bump) |=> (cnt_q == $past(cnt_q)))
    else $error("fill count changed without create");

  // a fresh response carries the status just computed
  a_rsp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> (rsp_valid_o && rsp_status_o == $past(status_d)))
    else $error("response register not loaded on issue");

endmodule : mtl_back
`default_nettype wire

// File: hdl/mutex_table_lock_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mutex_table_lock_unit_core: hardware mutex table
// Create, lock, trylock, unlock and owner query on a table of mutexes.
// ----------------------------------------------------------------------------
// A request beat is decoded by the front end, queued in a two-entry queue
// and executed by the back end as a read-modify-write of one table entry,
// so the unit sustains one request per cycle while responses are taken;
// the request passes through the queue and is then executed into the output
// register, from which its response is offered. One response may wait
// in the output register while the queue takes up to two further requests.
// Created entries form a prefix of the table, tracked by a fill count; lock
// state sits in flip-flops that reset clears at once, so no clearing pass is
// needed after reset. A lock held by another pid answers retry, and the
// requester is expected to ask again.
module mutex_table_lock_unit_core
  import mtl_pkg::*;
#(
  parameter int MUTEX_COUNT = MutexCountDef,
  parameter int PID_WIDTH   = PidWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtl_req_if.sink   req_i,
  mtl_rsp_if.source rsp_o
);

  logic push_valid, push_ready;
  req_t push_req;
  logic pop_valid, pop_ready;
  req_t pop_req;

  // decode
  mtl_front #(
    .MUTEX_COUNT (MUTEX_COUNT)
  ) u_front (
    .valid_i         (req_i.valid),
    .ready_o         (req_i.ready),
    .op_i            (req_i.op),
    .mutex_id_i      (req_i.mutex_id),
    .requester_pid_i (req_i.requester_pid),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_req_o      (push_req)
  );

  // queue
  mtl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  // execute
  mtl_back #(
    .MUTEX_COUNT (MUTEX_COUNT),
    .PID_WIDTH   (PID_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (pop_valid),
    .req_ready_o  (pop_ready),
    .req_i        (pop_req),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_value_o  (rsp_o.value),
    .rsp_wake_o   (rsp_o.wake_waiters)
  );

endmodule : mutex_table_lock_unit_core
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mutex_table_lock_unit_core
// Drives create, lock, trylock, unlock and owner requests through the
// request channel and checks every response against a mirror of the mutex
// table. It starts with a directed pass over the error and ownership cases,
// then runs lock/query/unlock sequences on random entries with random pids,
// mixed with stray requests. Sender bursts, receiver stalls and one long
// receiver hold-off exercise the queue and the output register.
// ----------------------------------------------------------------------------
module testbench;
  import mtl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MutexCount  = MutexCountDef;
  localparam int RandomItems = 1930;
  localparam int IdleLimit   = 2000;   // cycles with no beat on either side
  localparam int LongHold    = 400;    // receiver hold-off, in cycles
  localparam int HoldAfter   = 600;    // request beats before the hold-off
  localparam int DrainCycles = 8;
  localparam int ReportMax   = 10;

  // undefined operation codes, answered with an error
  localparam logic [OpW-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OpW-1:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
    logic               wake;
  } answer_t;

  // Mirror of the mutex table and the queue of answers still owed.
  class mutex_table_tracker;
    bit                 used   [MutexCount];
    bit                 locked [MutexCount];
    logic [RawPidW-1:0] owner  [MutexCount];
    answer_t            owed_answers [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < MutexCount; i++) begin
        used[i]   = 1'b0;
        locked[i] = 1'b0;
        owner[i]  = '0;
      end
      mismatches = 0;
    endfunction

    // update the table for an accepted request and queue its answer
    function void note_request(logic [OpW-1:0] op, logic [IdW-1:0] id,
                               logic [RawPidW-1:0] pid);
      answer_t ans;
      int      slot;
      ans  = '{status: ST_ERROR, value: '0, wake: 1'b0};
      slot = -1;
      if (op == OP_CREATE) begin
        // lowest unused entry
        for (int i = 0; i < MutexCount; i++)
          if (!used[i] && slot < 0) slot = i;
        if (slot >= 0) begin
          used[slot]   = 1'b1;
          locked[slot] = 1'b0;
          owner[slot]  = '0;
          ans.status   = ST_OK;
          ans.value    = ValueW'(slot);
        end
      end else if (op <= OP_OWNER && int'(id) < MutexCount && used[id]) begin
        case (op)
          OP_LOCK: begin
            if (!locked[id]) begin
              locked[id] = 1'b1;
              owner[id]  = pid;
              ans.status = ST_OK;
            end else if (owner[id] != pid) begin
              ans.status = ST_RETRY;
            end
          end
          OP_UNLOCK: begin
            if (locked[id] && owner[id] == pid) begin
              locked[id] = 1'b0;
              owner[id]  = '0;
              ans.status = ST_OK;
              ans.wake   = 1'b1;
            end
          end
          OP_TRYLOCK: begin
            if (!locked[id]) begin
              locked[id] = 1'b1;
              owner[id]  = pid;
              ans.status = ST_OK;
            end
          end
          default: begin
            ans.status = ST_OK;
            ans.value  = locked[id] ? ValueW'(owner[id]) : '0;
          end
        endcase
      end
      owed_answers.push_back(ans);
    endfunction

    // compare a response beat with the oldest owed answer
    function void check_response(logic [StatusW-1:0] status, logic [ValueW-1:0] value,
                                 logic wake);
      answer_t exp_ans;
      if (owed_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: response beat with nothing owed: status %0d value %h wake %b",
                   $realtime, status, value, wake);
        return;
      end
      exp_ans = owed_answers.pop_front();
      if (status !== exp_ans.status || value !== exp_ans.value || wake !== exp_ans.wake)
      begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: mismatch: exp status %0d value %h wake %b, got %0d %h %b",
                   $realtime, exp_ans.status, exp_ans.value, exp_ans.wake,
                   status, value, wake);
      end
    endfunction

    function int owed();
      return owed_answers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtl_req_if req_if ();
  mtl_rsp_if rsp_if ();

  mutex_table_tracker tracker = new();

  int                 req_beats = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  logic [RawPidW-1:0] pid_pool [4];

  mutex_table_lock_unit_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk = ~clk;

  // watch both channels, feed the tracker
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      tracker.note_request(req_if.op, req_if.mutex_id, req_if.requester_pid);
      req_beats++;
    end
    if (rst_n && rsp_if.valid && rsp_if.ready)
      tracker.check_response(rsp_if.status, rsp_if.value, rsp_if.wake_waiters);
  end

  // watchdog: ends the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no beat for %0d cycles", $realtime, IdleLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall patterns in phases, one long hold-off
  initial begin : rsp_drain
    int  mode;
    int  len;
    int  k;
    bit  held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 150);
      k    = 0;
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= $urandom_range(0, 1);
          2:       rsp_if.ready <= (k % 4 != 3);
          default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
        k++;
      end
      if (!held && req_beats >= HoldAfter) begin
        held = 1'b1;
        @(posedge clk);
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
    end
  end

  // offer one request beat, possibly opening a gap first when a burst has run out
  task automatic offer(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                       input logic [RawPidW-1:0] pid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid         <= 1'b1;
    req_if.op            <= op;
    req_if.mutex_id      <= id;
    req_if.requester_pid <= pid;
    do @(posedge clk); while (!req_if.ready);
  endtask

  function automatic logic [RawPidW-1:0] any_pid();
    return ($urandom_range(0, 4) == 0) ? RawPidW'($urandom_range(0, 65535))
                                       : pid_pool[$urandom_range(0, 3)];
  endfunction

  initial begin : req_feed
    logic [OpW-1:0]     single_ops [4];
    logic [IdW-1:0]     id;
    logic [RawPidW-1:0] holder;
    logic [RawPidW-1:0] rival;
    int                 sent;
    int                 pick;

    single_ops = '{OP_LOCK, OP_UNLOCK, OP_TRYLOCK, OP_OWNER};
    for (int i = 0; i < 4; i++) pid_pool[i] = RawPidW'($urandom_range(0, 65535));

    req_if.valid         <= 1'b0;
    req_if.op            <= OP_CREATE;
    req_if.mutex_id      <= '0;
    req_if.requester_pid <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: requests on entries not yet created
    offer(OP_OWNER,   4'd0,  16'h0001);
    offer(OP_LOCK,    4'd15, 16'hFFFF);
    offer(OP_UNLOCK,  4'd0,  16'hFFFF);
    offer(OP_TRYLOCK, 4'd0,  16'h0001);
    // undefined operations
    for (int i = int'(OP_RSVD_A); i <= int'(OP_RSVD_C); i++)
      offer(OpW'(i), 4'd15, 16'hFFFF);
    // create ignores the id field
    offer(OP_CREATE, 4'd15, 16'hFFFF);
    offer(OP_CREATE, 4'd0,  16'h0000);
    // lock ownership rules on entry 0
    offer(OP_LOCK,    4'd0, 16'hFFFF);
    offer(OP_LOCK,    4'd0, 16'hFFFF);  // relock by the owner
    offer(OP_LOCK,    4'd0, 16'h1234);  // held by another pid
    offer(OP_TRYLOCK, 4'd0, 16'hFFFF);  // trylock by the owner on a held entry
    offer(OP_OWNER,   4'd0, 16'h0001);
    offer(OP_UNLOCK,  4'd0, 16'h1234);  // not the owner
    offer(OP_UNLOCK,  4'd0, 16'hFFFF);
    offer(OP_UNLOCK,  4'd0, 16'hFFFF);  // already free
    offer(OP_OWNER,   4'd0, 16'h0001);
    // pid zero as an ordinary owner tag
    offer(OP_TRYLOCK, 4'd1, 16'h0000);
    offer(OP_OWNER,   4'd1, 16'hFFFF);
    offer(OP_UNLOCK,  4'd1, 16'h0000);
    offer(OP_LOCK,    4'd2, 16'h0001);

    // random: mostly grab/query/release sequences, with strays and creates
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      id   = IdW'($urandom_range(0, MutexCount - 1));
      if (pick < 55) begin
        holder = any_pid();
        rival  = pid_pool[$urandom_range(0, 3)];
        offer($urandom_range(0, 1) ? OP_LOCK : OP_TRYLOCK, id, holder);
        sent++;
        if ($urandom_range(0, 2) == 0) begin
          offer(OP_LOCK, id, rival);
          sent++;
        end
        offer(OP_OWNER, id, any_pid());
        offer(OP_UNLOCK, id, ($urandom_range(0, 4) == 0) ? rival : holder);
        sent += 2;
      end else if (pick < 62) begin
        offer(OP_CREATE, id, any_pid());
        sent++;
      end else if (pick < 66) begin
        // stray request with an undefined operation
        offer(OpW'($urandom_range(int'(OP_RSVD_A), int'(OP_RSVD_C))), id, any_pid());
      end else begin
        offer(single_ops[$urandom_range(0, 3)], id, any_pid());
        sent++;
      end
    end
    req_if.valid <= 1'b0;

    // drain; the last request beat is noted by the monitor at this edge
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule : testbench
`default_nettype wire

// File: mutex_table_lock_unit_core.f
hdl/mtl_pkg.sv
hdl/mtl_req_if.sv
hdl/mtl_rsp_if.sv
hdl/mtl_front.sv
hdl/mtl_fifo.sv
hdl/mtl_back.sv
hdl/mutex_table_lock_unit_core.sv
tb/testbench.sv
